// ===== hdl/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// Scaled sine generator package
// Shared constants, register codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ssg_pkg;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 16;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_CYCLES    = 3'd0,
        CFG_AMPLITUDE = 3'd1,
        CFG_PHASE     = 3'd2,
        CFG_WINDOW    = 3'd3,
        CFG_OFFSET    = 3'd4
    } cfg_reg_t;

    localparam int INDEX_BITS     = 16;
    localparam int AMP_BITS       = 15;
    localparam int PHASE_BITS     = 8;
    localparam int ANGLE_BITS     = 24;
    localparam int PRODUCT_BITS   = 2 * INDEX_BITS;
    localparam int SINE_BITS      = 16;

    localparam int DIV_BITS_PER_ROUND = 2;
    localparam int DIV_ROUNDS     = (PRODUCT_BITS + ANGLE_BITS) / DIV_BITS_PER_ROUND;
    localparam int DIV_COUNT_BITS = $clog2(DIV_ROUNDS);

    localparam logic signed [30:0] TURN_INV_Q32 = 31'sd683565276;

    localparam int CORDIC_BITS = 34;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_X0 = 34'sd652032874;
    localparam logic signed [CORDIC_BITS-1:0] CORDIC_ROUND = 34'sd16384;
    localparam int CORDIC_FRAC_SHIFT = 15;
    localparam logic signed [CORDIC_BITS-1:0] SINE_MAX = 34'sd32767;
    localparam logic signed [CORDIC_BITS-1:0] SINE_MIN = -34'sd32767;

    localparam logic [ANGLE_BITS-1:0] QUARTER_TURN = 24'h400000;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN    = 24'h800000;
    localparam logic [ANGLE_BITS-1:0] THREE_QUARTER_TURN = 24'hC00000;

    localparam int ATAN_COUNT = 24;
    localparam int ATAN_BITS  = 30;
    localparam int ATAN_INDEX_BITS = $clog2(ATAN_COUNT);

    localparam logic [ATAN_BITS-1:0] ATAN_TURN_Q32 [ATAN_COUNT] = '{
        30'd536870912, 30'd316933406, 30'd167458907, 30'd85004756,
        30'd42667331,  30'd21354465,  30'd10679838,  30'd5340245,
        30'd2670163,   30'd1335087,   30'd667544,    30'd333772,
        30'd166886,    30'd83443,     30'd41722,     30'd20861,
        30'd10430,     30'd5215,      30'd2608,      30'd1304,
        30'd652,       30'd326,       30'd163,       30'd81
    };

endpackage

// ===== hdl/scaled_sine_sample_generator_unit.sv =====
// ----------------------------------------------------------------------------
// Scaled sine sample generator
// Each input transaction yields one sine sample scaled by amplitude, shifted
// by dc_offset and saturated; the last sample of each window carries tlast.
// ----------------------------------------------------------------------------
// The input is ready again in the cycle in which the result is registered, so
// a new input transaction is taken only once the previous sample is through.
// A sample passes the multiply state, the radix-4 ramp divider (56-bit
// dividend) and the CORDIC, which performs one micro-rotation per cycle,
// before the scaled and offset sum is registered. A finished sample
// waits in the output register while the next input transaction is taken;
// a stalled sink holds the block only once the following sample is ready
// too. Configuration writes take effect at once and belong in idle periods.
module scaled_sine_sample_generator_unit
    import ssg_pkg::*;
#(
    parameter int SAMPLE_BITS  = 16,
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [CFG_INDEX_BITS-1:0]          cfg_index,
    input  logic [CFG_DATA_BITS-1:0]           cfg_data,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [7:0]                         s_tdata,  // [0] restart
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [((SAMPLE_BITS+7)/8)*8-1:0]   m_tdata,  // [SAMPLE_BITS-1:0] sample
    output logic                               m_tlast   // last_of_window
);

    localparam int DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int SUM_BITS  = 18;
    localparam int CMP_BITS  = (SAMPLE_BITS + 1 > SUM_BITS) ? SAMPLE_BITS + 1 : SUM_BITS;
    localparam int SCALE_BITS = 2 * SINE_BITS;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_ROT,
        ST_SUM
    } state_t;

    state_t                          state_reg;
    logic [INDEX_BITS-1:0]           cycles_reg;
    logic [AMP_BITS-1:0]             amplitude_reg;
    logic signed [PHASE_BITS-1:0]    phase_reg;
    logic [INDEX_BITS-1:0]           window_reg;
    logic [INDEX_BITS-1:0]           offset_reg;
    logic [INDEX_BITS-1:0]           sample_index_reg;
    logic [INDEX_BITS-1:0]           idx_reg;
    logic                            last_reg;
    logic [ANGLE_BITS-1:0]           phase_turn_reg;
    logic signed [SCALE_BITS-1:0]    scale_reg;
    logic                            m_valid_reg;
    logic [SAMPLE_BITS-1:0]          m_sample_reg;
    logic                            m_last_reg;

    logic [INDEX_BITS-1:0]           n_eff;
    logic [INDEX_BITS-1:0]           idx_eff;
    logic                            idx_last;
    logic                            in_take;
    logic [PRODUCT_BITS-1:0]         ramp_product;
    logic signed [38:0]              phase_product;
    logic                            div_start;
    logic                            div_done;
    logic [ANGLE_BITS-1:0]           div_quotient;
    logic                            rot_start;
    logic [ANGLE_BITS-1:0]           rot_angle;
    logic                            rot_done;
    logic signed [SINE_BITS-1:0]     rot_sine;
    logic signed [SINE_BITS:0]       scaled;
    logic signed [SUM_BITS-1:0]      value;
    logic signed [CMP_BITS-1:0]      value_wide;
    logic signed [CMP_BITS-1:0]      value_max;
    logic [SAMPLE_BITS-1:0]          sample_sat;
    logic                            out_free;

    always_comb
    begin
        n_eff    = (window_reg == '0) ? INDEX_BITS'(1) : window_reg;
        idx_eff  = (s_tdata[0] || (sample_index_reg >= n_eff)) ? '0 : sample_index_reg;
        idx_last = (idx_eff == n_eff - 1'b1);
        in_take  = s_tvalid && s_tready;

        ramp_product  = idx_reg * cycles_reg;
        phase_product = phase_reg * TURN_INV_Q32;
        div_start     = (state_reg == ST_MUL);
        rot_start     = (state_reg == ST_DIV) && div_done;
        rot_angle     = div_quotient + phase_turn_reg;

        scaled     = (SINE_BITS+1)'(scale_reg >>> CORDIC_FRAC_SHIFT);
        value      = SUM_BITS'(scaled) + $signed({2'b00, offset_reg});
        value_wide = CMP_BITS'(value);
        value_max  = $signed({{(CMP_BITS-SAMPLE_BITS){1'b0}}, {SAMPLE_BITS{1'b1}}});
        priority if (value_wide < 0)
        begin
            sample_sat = '0;
        end
        else if (value_wide > value_max)
        begin
            sample_sat = '1;
        end
        else
        begin
            sample_sat = value_wide[SAMPLE_BITS-1:0];
        end
        out_free = !m_valid_reg || m_tready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cycles_reg    <= INDEX_BITS'(1);
            amplitude_reg <= '0;
            phase_reg     <= '0;
            window_reg    <= INDEX_BITS'(64);
            offset_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_CYCLES:    cycles_reg    <= cfg_data;
                CFG_AMPLITUDE: amplitude_reg <= cfg_data[AMP_BITS-1:0];
                CFG_PHASE:     phase_reg     <= $signed(cfg_data[PHASE_BITS-1:0]);
                CFG_WINDOW:    window_reg    <= cfg_data;
                CFG_OFFSET:    offset_reg    <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            sample_index_reg <= '0;
            idx_reg          <= '0;
            last_reg         <= 1'b0;
            phase_turn_reg   <= '0;
            scale_reg        <= '0;
            m_valid_reg      <= 1'b0;
            m_sample_reg     <= '0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            if (m_valid_reg && m_tready && !((state_reg == ST_SUM) && out_free))
            begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        idx_reg          <= idx_eff;
                        last_reg         <= idx_last;
                        sample_index_reg <= idx_last ? '0 : idx_eff + 1'b1;
                        state_reg        <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    phase_turn_reg <= phase_product[31:8];
                    state_reg      <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_ROT;
                    end
                end
                ST_ROT:
                begin
                    if (rot_done)
                    begin
                        scale_reg <= $signed({1'b0, amplitude_reg}) * rot_sine;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM:
                begin
                    if (out_free)
                    begin
                        m_sample_reg <= sample_sat;
                        m_last_reg   <= last_reg;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ssg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (ramp_product),
        .divisor  (n_eff),
        .done     (div_done),
        .quotient (div_quotient)
    );

    ssg_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (rot_start),
        .angle (rot_angle),
        .done  (rot_done),
        .sine  (rot_sine)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = DATA_BITS'(m_sample_reg);
    assign m_tlast  = m_last_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> !s_tready)
        else $error("input taken while a sample is in progress");

    a_index_in_window: assert property (@(posedge clk) disable iff (!rst_n)
        in_take |=> (sample_index_reg < $past(n_eff)))
        else $error("sample index left the window");

    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_SUM) && out_free) |=> (m_valid_reg && s_tready))
        else $error("finished sample not presented");

endmodule

// ===== hdl/ssg_div.sv =====
// ----------------------------------------------------------------------------
// Ramp angle divider
// Radix-4 restoring division of (product * 2^24) by the window length,
// two quotient bits per cycle; keeps the low 24 quotient bits (the angle).
// ----------------------------------------------------------------------------
module ssg_div
    import ssg_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic [PRODUCT_BITS-1:0] dividend,
    input  logic [INDEX_BITS-1:0]   divisor,
    output logic                    done,
    output logic [ANGLE_BITS-1:0]   quotient
);

    logic                      busy_reg;
    logic                      done_reg;
    logic [DIV_COUNT_BITS-1:0] count_reg;
    logic [PRODUCT_BITS-1:0]   dvd_reg;
    logic [INDEX_BITS-1:0]     dsr_reg;
    logic [INDEX_BITS-1:0]     rem_reg;
    logic [ANGLE_BITS-1:0]     quo_reg;

    logic [INDEX_BITS:0]       trial_hi;
    logic [INDEX_BITS:0]       trial_lo;
    logic [INDEX_BITS-1:0]     rem_mid;
    logic [INDEX_BITS-1:0]     rem_next;
    logic                      qbit_hi;
    logic                      qbit_lo;

    always_comb
    begin
        trial_hi = {rem_reg, dvd_reg[PRODUCT_BITS-1]};
        qbit_hi  = (trial_hi >= {1'b0, dsr_reg});
        if (qbit_hi)
        begin
            trial_hi = trial_hi - {1'b0, dsr_reg};
        end
        rem_mid  = trial_hi[INDEX_BITS-1:0];
        trial_lo = {rem_mid, dvd_reg[PRODUCT_BITS-2]};
        qbit_lo  = (trial_lo >= {1'b0, dsr_reg});
        if (qbit_lo)
        begin
            trial_lo = trial_lo - {1'b0, dsr_reg};
        end
        rem_next = trial_lo[INDEX_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
            dvd_reg   <= '0;
            dsr_reg   <= '0;
            rem_reg   <= '0;
            quo_reg   <= '0;
        end
        else
        begin
            done_reg <= !start && busy_reg
                        && (count_reg == DIV_COUNT_BITS'(DIV_ROUNDS - 1));
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= '0;
                dvd_reg   <= dividend;
                dsr_reg   <= divisor;
                rem_reg   <= '0;
                quo_reg   <= '0;
            end
            else if (busy_reg)
            begin
                dvd_reg   <= {dvd_reg[PRODUCT_BITS-3:0], 2'b00};
                rem_reg   <= rem_next;
                quo_reg   <= {quo_reg[ANGLE_BITS-3:0], qbit_hi, qbit_lo};
                count_reg <= count_reg + 1'b1;
                if (count_reg == DIV_COUNT_BITS'(DIV_ROUNDS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (count_reg <= DIV_COUNT_BITS'(DIV_ROUNDS - 1)))
        else $error("divider round count out of range");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> ($past(busy_reg) && !busy_reg))
        else $error("divider done without a finished division");

endmodule

// ===== hdl/ssg_cordic.sv =====
// ----------------------------------------------------------------------------
// Iterative sine CORDIC
// Rotation-mode CORDIC, one micro-rotation per cycle, with half-turn
// folding and Q1.15 rounding of the sine.
// ----------------------------------------------------------------------------
module ssg_cordic
    import ssg_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ANGLE_BITS-1:0]       angle,
    output logic                        done,
    output logic signed [SINE_BITS-1:0] sine
);

    localparam int STEP_BITS = $clog2(CORDIC_STEPS);

    logic                          busy_reg;
    logic                          fin_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [STEP_BITS-1:0]          step_reg;
    logic signed [CORDIC_BITS-1:0] x_reg;
    logic signed [CORDIC_BITS-1:0] y_reg;
    logic signed [CORDIC_BITS-1:0] z_reg;
    logic signed [SINE_BITS-1:0]   sine_reg;

    logic                          fold;
    logic [ANGLE_BITS-1:0]         turn;
    logic signed [CORDIC_BITS-1:0] z_init;
    logic signed [CORDIC_BITS-1:0] dx;
    logic signed [CORDIC_BITS-1:0] dy;
    logic signed [CORDIC_BITS-1:0] atan;
    logic signed [CORDIC_BITS-1:0] rounded;
    logic signed [CORDIC_BITS-1:0] clamped;
    logic signed [SINE_BITS-1:0]   sine_mag;

    always_comb
    begin
        fold   = (angle >= QUARTER_TURN) && (angle < THREE_QUARTER_TURN);
        turn   = fold ? (angle - HALF_TURN) : angle;
        z_init = CORDIC_BITS'($signed({turn, 8'h00}));
        dx     = y_reg >>> step_reg;
        dy     = x_reg >>> step_reg;
        atan   = $signed({{(CORDIC_BITS-ATAN_BITS){1'b0}},
                          ATAN_TURN_Q32[ATAN_INDEX_BITS'(step_reg)]});
        rounded = (y_reg + CORDIC_ROUND) >>> CORDIC_FRAC_SHIFT;
        priority if (rounded > SINE_MAX)
        begin
            clamped = SINE_MAX;
        end
        else if (rounded < SINE_MIN)
        begin
            clamped = SINE_MIN;
        end
        else
        begin
            clamped = rounded;
        end
        sine_mag = clamped[SINE_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            done_reg <= 1'b0;
            neg_reg  <= 1'b0;
            step_reg <= '0;
            x_reg    <= '0;
            y_reg    <= '0;
            z_reg    <= '0;
            sine_reg <= '0;
        end
        else
        begin
            fin_reg  <= !start && busy_reg
                        && (step_reg == STEP_BITS'(CORDIC_STEPS - 1));
            done_reg <= fin_reg;
            if (start)
            begin
                busy_reg <= 1'b1;
                neg_reg  <= fold;
                step_reg <= '0;
                x_reg    <= CORDIC_X0;
                y_reg    <= '0;
                z_reg    <= z_init;
            end
            else if (busy_reg)
            begin
                if (z_reg >= 0)
                begin
                    x_reg <= x_reg - dx;
                    y_reg <= y_reg + dy;
                    z_reg <= z_reg - atan;
                end
                else
                begin
                    x_reg <= x_reg + dx;
                    y_reg <= y_reg - dy;
                    z_reg <= z_reg + atan;
                end
                step_reg <= step_reg + 1'b1;
                if (step_reg == STEP_BITS'(CORDIC_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (fin_reg)
            begin
                sine_reg <= neg_reg ? -sine_mag : sine_mag;
            end
        end
    end

    assign done = done_reg;
    assign sine = sine_reg;

    a_sine_clamped: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> (sine_reg != {1'b1, {(SINE_BITS-1){1'b0}}}))
        else $error("sine left the symmetric Q1.15 range");

endmodule

// ===== tb/sv/tb_scaled_sine_sample_generator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Scaled sine sample generator testbench
// Drives tick transactions under random source gaps and sink stalls and
// checks every sample and window flag. Expected values come from a
// behavioural copy of the generator: window ramp, phase in turns, 16-step
// CORDIC and saturation. A short directed table covers reset values,
// saturation, zero and lowered window lengths, phase extremes and restarts.
// Random register settings, most with short windows, follow.
// ----------------------------------------------------------------------------
module tb_scaled_sine_sample_generator_unit;
    import ssg_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_ITEMS  = 1200;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int SINE_STEPS    = 16;

    localparam longint GAIN_START_X = 64'sd652032874;
    localparam longint RAD_TO_TURN  = 64'sd683565276;
    localparam longint ARC_STEP_TURN [SINE_STEPS] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    typedef enum logic { ROW_WRITE, ROW_TICK } row_kind_t;

    typedef struct packed {
        logic [15:0] value;
        logic        last;
    } sample_t;

    typedef struct packed {
        logic    typed;
        sample_t want;
    } hint_t;

    typedef struct packed {
        row_kind_t   kind;
        cfg_reg_t    addr;
        logic [15:0] value;
        logic        restart;
        logic        typed;
        logic [15:0] want_value;
        logic        want_last;
    } row_t;

    logic                      clk       = 1'b0;
    logic                      rst_n     = 1'b0;
    logic                      cfg_we    = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_CYCLES;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
    logic                      s_tvalid  = 1'b0;
    logic                      s_tready;
    logic [7:0]                s_tdata   = '0;   // [0] restart
    logic                      m_tvalid;
    logic                      m_tready  = 1'b0;
    logic [15:0]               m_tdata;          // [15:0] sample
    logic                      m_tlast;          // last_of_window

    logic [15:0] cycles_set;
    logic [14:0] amp_set;
    logic [7:0]  phase_set;
    logic [15:0] window_set;
    logic [15:0] offset_set;
    logic [15:0] gen_index;

    sample_t sample_q [$];
    hint_t   hint_q [$];

    int mismatches    = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int wraps_seen    = 0;
    int restarts_sent = 0;
    int writes_done   = 0;
    int settings_run  = 0;
    int cycle_count   = 0;
    int send_calm     = 0;
    int recv_calm     = 0;
    bit in_flight     = 1'b0;

    row_t directed_rows [$] = '{
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b1, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b1, 1'b1, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b1, 16'd65535, 1'b0},
        '{ROW_WRITE, CFG_WINDOW,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd1234,  1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b1, 16'd1234,  1'b1},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b1, 1'b1, 16'd1234,  1'b1},
        '{ROW_WRITE, CFG_WINDOW,    16'd64,    1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_AMPLITUDE, 16'd32767, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_PHASE,     16'd1,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b1, 1'b1, 16'd65535, 1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_PHASE,     16'h00FF,  1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b1, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_PHASE,     16'd127,   1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd32768, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_PHASE,     16'h0080,  1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_PHASE,     16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_CYCLES,    16'd1,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_WINDOW,    16'd4,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b1, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_WINDOW,    16'd64,    1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_CYCLES,    16'd3,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_WINDOW,    16'd2,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_AMPLITUDE, 16'd12345, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_CYCLES,    16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_WINDOW,    16'd65535, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_WRITE, CFG_OFFSET,    16'd32767, 1'b0, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b1, 1'b0, 16'd0,     1'b0},
        '{ROW_TICK,  CFG_CYCLES,    16'd0,     1'b0, 1'b0, 16'd0,     1'b0}
    };

    scaled_sine_sample_generator_unit uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #CLK_HALF clk = ~clk;

    function automatic int cordic_sine(input logic [23:0] turn);
        logic [23:0] t;
        logic        neg;
        longint      x;
        longint      y;
        longint      z;
        longint      dx;
        longint      dy;
        longint      s;
        t   = turn;
        neg = 1'b0;
        if (t >= QUARTER_TURN && t < THREE_QUARTER_TURN)
        begin
            t   = t - HALF_TURN;
            neg = 1'b1;
        end
        z = longint'($signed({t, 8'h00}));
        x = GAIN_START_X;
        y = 0;
        for (int k = 0; k < SINE_STEPS; k++)
        begin
            dx = y >>> k;
            dy = x >>> k;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - ARC_STEP_TURN[k];
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + ARC_STEP_TURN[k];
            end
        end
        s = (y + 16384) >>> 15;
        if (s > 32767)
            s = 32767;
        if (s < -32767)
            s = -32767;
        return neg ? -int'(s) : int'(s);
    endfunction

    task automatic synth_sample(input logic restart, output sample_t res);
        logic [63:0] n;
        logic [63:0] use_idx;
        logic [63:0] ramp;
        logic [63:0] a24;
        logic [31:0] p32;
        logic [23:0] angle;
        longint      p;
        longint      v;
        int          s;
        n = (window_set == 16'd0) ? 64'd1 : 64'(window_set);
        if (restart)
            gen_index = '0;
        use_idx = 64'(gen_index);
        if (use_idx >= n)
            use_idx = 64'd0;
        ramp  = (use_idx * 64'(cycles_set)) % n;
        a24   = (ramp << 24) / n;
        p     = longint'($signed(phase_set)) * RAD_TO_TURN;
        p32   = p[31:0];
        angle = a24[23:0] + p32[31:8];
        s     = cordic_sine(angle);
        v     = ((longint'(amp_set) * longint'(s)) >>> 15) + longint'(offset_set);
        if (v < 0)
            v = 0;
        if (v > 65535)
            v = 65535;
        res.value = v[15:0];
        res.last  = (use_idx == n - 64'd1);
        gen_index = res.last ? 16'd0 : 16'(use_idx + 64'd1);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH %s: got %0d, expected %0d (result %0d, t=%0t)",
                 what, got, want, results_seen, $realtime);
        mismatches++;
    endtask

    function automatic int draw_gap(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 9) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 19);
    endfunction

    function automatic logic [15:0] draw_setting(input logic [15:0] top,
                                                 input logic [15:0] usual_max);
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return top;
            2:       return 16'($urandom);
            default: return 16'($urandom_range(0, usual_max));
        endcase
    endfunction

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (results_seen < items_sent)
            @(posedge clk);
        in_flight = 1'b0;
    endtask

    task automatic write_reg(input cfg_reg_t addr, input logic [15:0] value);
        if (in_flight)
            settle_block();
        cfg_we    <= 1'b1;
        cfg_index <= addr;
        cfg_data  <= value;
        @(posedge clk);
        writes_done++;
    endtask

    task automatic send_tick(input logic restart, input hint_t hint);
        int gap;
        gap = draw_gap(send_calm);
        cfg_we <= 1'b0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        hint_q.insert(hint_q.size(), hint);
        s_tdata  <= {7'd0, restart};
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        in_flight = 1'b1;
        if (restart)
            restarts_sent++;
    endtask

    // mirror register writes, check results, predict accepted ticks
    always @(posedge clk)
    begin
        sample_t want;
        hint_t   hint;
        if (!rst_n)
        begin
            cycles_set = 16'd1;
            amp_set    = '0;
            phase_set  = '0;
            window_set = 16'd64;
            offset_set = '0;
            gen_index  = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    CFG_CYCLES:    cycles_set = cfg_data;
                    CFG_AMPLITUDE: amp_set    = cfg_data[14:0];
                    CFG_PHASE:     phase_set  = cfg_data[7:0];
                    CFG_WINDOW:    window_set = cfg_data;
                    CFG_OFFSET:    offset_set = cfg_data;
                    default:       ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                if (sample_q.size() == 0)
                    report_mismatch("unexpected sample", m_tdata, -1);
                else
                begin
                    want = sample_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch("sample", m_tdata, want.value);
                    if (m_tlast !== want.last)
                        report_mismatch("last_of_window", m_tlast, want.last);
                end
                results_seen++;
                if (m_tlast)
                    wraps_seen++;
            end
            if (s_tvalid && s_tready)
            begin
                hint = (hint_q.size() != 0) ? hint_q.pop_front() : '0;
                synth_sample(s_tdata[0], want);
                if (hint.typed)
                    want = hint.want;
                sample_q.insert(sample_q.size(), want);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d of %0d samples seen",
                     cycle_count, results_seen, items_sent);
            $display("tb_scaled_sine_sample_generator_unit: done, errors");
            $finish;
        end
    end

    initial
    begin
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = draw_gap(recv_calm);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
        end
    end

    initial
    begin
        int    directed_items;
        int    random_items;
        int    burst;
        hint_t hint;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_WRITE)
                write_reg(directed_rows[r].addr, directed_rows[r].value);
            else
            begin
                hint.typed      = directed_rows[r].typed;
                hint.want.value = directed_rows[r].want_value;
                hint.want.last  = directed_rows[r].want_last;
                send_tick(directed_rows[r].restart, hint);
            end
        end
        directed_items = items_sent;

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            write_reg(CFG_CYCLES,    draw_setting(16'd65535, 16'd9));
            write_reg(CFG_AMPLITUDE, draw_setting(16'd32767, 16'd32767));
            write_reg(CFG_PHASE,     draw_setting(16'd127, 16'd255));
            write_reg(CFG_WINDOW,    draw_setting(16'd65535, 16'd100));
            write_reg(CFG_OFFSET,    draw_setting(16'd65535, 16'd65535));
            // unused register index: must leave every setting alone
            if ($urandom_range(0, 2) == 0)
                write_reg(cfg_reg_t'($urandom_range(int'(CFG_OFFSET) + 1,
                                                    (1 << CFG_INDEX_BITS) - 1)),
                          16'($urandom));
            settings_run++;
            burst = $urandom_range(60, 140);
            hint  = '0;
            repeat (burst)
            begin
                send_tick($urandom_range(0, 15) == 0, hint);
                random_items++;
            end
        end

        settle_block();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sample_q.size() != 0)
            report_mismatch("samples never delivered", sample_q.size(), 0);

        $display("Checked %0d directed and %0d random samples over %0d random settings",
                 directed_items, random_items, settings_run);
        $display("%0d window ends flagged, %0d restarts, %0d register writes",
                 wraps_seen, restarts_sent, writes_done);
        if (mismatches == 0)
            $display("tb_scaled_sine_sample_generator_unit: done, clean");
        else
            $display("tb_scaled_sine_sample_generator_unit: done, errors");
        $finish;
    end

endmodule
